FILE: rtl/core/hsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the point-set Hausdorff distance block.
// Used by every module under rtl/core; depends on nothing.
package hsd_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 24;
    localparam int DIST_W         = 26;
    localparam int DSQ_OUT_W      = 50;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_ROOT,
        ST_WAIT,
        ST_OUT
    } state_t;

    // Control that travels with each point pair down the distance pipeline
    typedef struct packed {
        logic vld;
        logic first;
        logic last_j;
        logic done;
    } tag_t;

endpackage

FILE: rtl/core/hsd_root_cell.sv
`timescale 1ns / 1ps
// One digit step of the integer square root: takes two radicand bits per cell.
// Depends on hsd_pkg for the default coordinate width.
module hsd_root_cell #(
    parameter int DSQ_W  = 2 * hsd_pkg::COORD_BITS_DEF + 2,
    parameter int ROOT_W = DSQ_W / 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              vld_i,
    input  logic [DSQ_W-1:0]  x_i,
    input  logic [ROOT_W:0]   r_i,
    input  logic [ROOT_W-1:0] q_i,
    output logic              vld_o,
    output logic [DSQ_W-1:0]  x_o,
    output logic [ROOT_W:0]   r_o,
    output logic [ROOT_W-1:0] q_o
);

    logic              vld_reg;
    logic [DSQ_W-1:0]  x_reg, x_next;
    logic [ROOT_W:0]   r_reg, r_next;
    logic [ROOT_W-1:0] q_reg, q_next;
    logic [ROOT_W+2:0] trial_rem;
    logic [ROOT_W+2:0] trial_sub;

    // Bring down two bits, try subtracting 4q+1
    always_comb begin
        trial_rem = {r_i, x_i[DSQ_W-1 -: 2]};
        trial_sub = {1'b0, q_i, 2'b01};
        x_next    = x_i << 2;
        if (trial_rem >= trial_sub) begin
            r_next = (ROOT_W + 1)'(trial_rem - trial_sub);
            q_next = {q_i[ROOT_W-2:0], 1'b1};
        end else begin
            r_next = (ROOT_W + 1)'(trial_rem);
            q_next = {q_i[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_i;
        end
        x_reg <= x_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign vld_o = vld_reg;
    assign x_o   = x_reg;
    assign r_o   = r_reg;
    assign q_o   = q_reg;

endmodule

FILE: rtl/core/hsd_root_chain.sv
`timescale 1ns / 1ps
// Row of square-root cells, one result bit per cell, each cell a register stage.
// Depends on hsd_pkg and hsd_root_cell.
module hsd_root_chain #(
    parameter int DSQ_W  = 2 * hsd_pkg::COORD_BITS_DEF + 2,
    parameter int ROOT_W = DSQ_W / 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              vld_i,
    input  logic [DSQ_W-1:0]  x_i,
    output logic              vld_o,
    output logic [ROOT_W-1:0] root_o
);

    logic              vld_s [0:ROOT_W];
    logic [DSQ_W-1:0]  x_s   [0:ROOT_W];
    logic [ROOT_W:0]   r_s   [0:ROOT_W];
    logic [ROOT_W-1:0] q_s   [0:ROOT_W];

    // Feed the head of the chain
    assign vld_s[0] = vld_i;
    assign x_s[0]   = x_i;
    assign r_s[0]   = '0;
    assign q_s[0]   = '0;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
        hsd_root_cell #(
            .DSQ_W  (DSQ_W),
            .ROOT_W (ROOT_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .vld_i   (vld_s[k]),
            .x_i     (x_s[k]),
            .r_i     (r_s[k]),
            .q_i     (q_s[k]),
            .vld_o   (vld_s[k+1]),
            .x_o     (x_s[k+1]),
            .r_o     (r_s[k+1]),
            .q_o     (q_s[k+1])
        );
    end

    assign vld_o  = vld_s[ROOT_W];
    assign root_o = q_s[ROOT_W];

endmodule

FILE: rtl/core/hsd_dist_pipe.sv
`timescale 1ns / 1ps
// Three-stage squared Euclidean distance: differences, squares, sum.
// Depends on hsd_pkg for the tag type.
module hsd_dist_pipe #(
    parameter int COORD_BITS = hsd_pkg::COORD_BITS_DEF,
    parameter int DSQ_W      = 2 * COORD_BITS + 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hsd_pkg::tag_t               tag_i,
    input  logic [3*COORD_BITS-1:0]     pa_i,
    input  logic [3*COORD_BITS-1:0]     pb_i,
    output hsd_pkg::tag_t               tag_o,
    output logic [DSQ_W-1:0]            dsq_o
);

    localparam int C = COORD_BITS;

    hsd_pkg::tag_t      tag2_reg, tag3_reg, tag4_reg;
    logic signed [C:0]  dx_reg, dy_reg, dz_reg;
    logic signed [C:0]  dx_next, dy_next, dz_next;
    logic signed [DSQ_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [DSQ_W-1:0]   sum_reg, sum_next;

    // Coordinate differences with one guard bit
    always_comb begin
        dx_next = $signed({pa_i[C-1], pa_i[C-1:0]})
                - $signed({pb_i[C-1], pb_i[C-1:0]});
        dy_next = $signed({pa_i[2*C-1], pa_i[2*C-1:C]})
                - $signed({pb_i[2*C-1], pb_i[2*C-1:C]});
        dz_next = $signed({pa_i[3*C-1], pa_i[3*C-1:2*C]})
                - $signed({pb_i[3*C-1], pb_i[3*C-1:2*C]});
        sum_next = DSQ_W'(sx_reg) + DSQ_W'(sy_reg) + DSQ_W'(sz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end else begin
            tag2_reg <= tag_i;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dz_reg  <= dz_next;
        sx_reg  <= DSQ_W'(dx_reg * dx_reg);
        sy_reg  <= DSQ_W'(dy_reg * dy_reg);
        sz_reg  <= DSQ_W'(dz_reg * dz_reg);
        sum_reg <= sum_next;
    end

    assign tag_o = tag4_reg;
    assign dsq_o = sum_reg;

endmodule

FILE: rtl/core/point_set_hausdorff_distance.sv
`timescale 1ns / 1ps
// Load, clear: one transaction per cycle while idle. Compute: one point pair per cycle
// goes through the distance pipeline, A against B and then B against A, and the result
// then through the square-root cell row (ROOT_W = COORD_BITS+1); empty sets skip both.
// One transaction at a time while computing; the result is held until taken.
// Synchronous active-low reset empties both sets and clears the drop flag.
module point_set_hausdorff_distance #(
    parameter int MAX_POINTS = hsd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = hsd_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic signed [COORD_BITS-1:0]  s_x_coord,
    input  logic signed [COORD_BITS-1:0]  s_y_coord,
    input  logic signed [COORD_BITS-1:0]  s_z_coord,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hsd_pkg::DIST_W-1:0]    m_distance,
    output logic [hsd_pkg::DSQ_OUT_W-1:0] m_distance_squared,
    output logic                          m_is_infinite,
    output logic                          m_overflow_drop
);

    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PT_W   = 3 * COORD_BITS;
    localparam int DSQ_W  = 2 * COORD_BITS + 2;
    localparam int ROOT_W = DSQ_W / 2;

    hsd_pkg::state_t state_reg, state_next;
    hsd_pkg::op_t    op;

    logic [PT_W-1:0]  mem_a [0:MAX_POINTS-1];
    logic [PT_W-1:0]  mem_b [0:MAX_POINTS-1];
    logic [PT_W-1:0]  rd_a_reg, rd_b_reg;

    logic [CNT_W-1:0] count_a_reg, count_b_reg;
    logic             drop_reg;
    logic [IDX_W-1:0] i_reg, j_reg;
    logic             dir_reg;
    logic [CNT_W-1:0] np, nq;
    logic             last_i, last_j;
    logic [IDX_W-1:0] addr_a, addr_b;

    hsd_pkg::tag_t    issue_tag, tag1_reg, tag4;
    logic [DSQ_W-1:0] dsq4, new_min;
    logic [DSQ_W-1:0] min_reg, best_reg;

    logic             root_vld;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] res_root_reg;
    logic [DSQ_W-1:0] res_dsq_reg;
    logic             res_inf_reg;

    logic s_fire, walk_en, launch_root, a_empty, b_empty, any_empty;

    assign op        = hsd_pkg::op_t'(s_op);
    assign s_fire    = s_valid && s_ready;
    assign a_empty   = (count_a_reg == '0);
    assign b_empty   = (count_b_reg == '0);
    assign any_empty = a_empty || b_empty;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hsd_pkg::ST_IDLE: begin
                if (s_fire && op == hsd_pkg::OP_COMPUTE) begin
                    state_next = any_empty ? hsd_pkg::ST_OUT : hsd_pkg::ST_WALK;
                end
            end
            hsd_pkg::ST_WALK: begin
                if (last_i && last_j && dir_reg) state_next = hsd_pkg::ST_DRAIN;
            end
            hsd_pkg::ST_DRAIN: begin
                if (tag4.vld && tag4.done) state_next = hsd_pkg::ST_ROOT;
            end
            hsd_pkg::ST_ROOT: state_next = hsd_pkg::ST_WAIT;
            hsd_pkg::ST_WAIT: begin
                if (root_vld) state_next = hsd_pkg::ST_OUT;
            end
            hsd_pkg::ST_OUT: begin
                if (m_ready) state_next = hsd_pkg::ST_IDLE;
            end
            default: state_next = hsd_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready     = (state_reg == hsd_pkg::ST_IDLE);
        m_valid     = (state_reg == hsd_pkg::ST_OUT);
        walk_en     = (state_reg == hsd_pkg::ST_WALK);
        launch_root = (state_reg == hsd_pkg::ST_ROOT);
    end

    // Walk indexes: outer point i of one set against inner point j of the other
    always_comb begin
        np        = dir_reg ? count_b_reg : count_a_reg;
        nq        = dir_reg ? count_a_reg : count_b_reg;
        last_i    = (CNT_W'(i_reg) == np - CNT_W'(1));
        last_j    = (CNT_W'(j_reg) == nq - CNT_W'(1));
        addr_a    = dir_reg ? j_reg : i_reg;
        addr_b    = dir_reg ? i_reg : j_reg;
        issue_tag.vld    = walk_en;
        issue_tag.first  = (j_reg == '0);
        issue_tag.last_j = last_j;
        issue_tag.done   = last_i && last_j && dir_reg;
    end

    // Point stores: write on load, registered read during the walk
    always_ff @(posedge aclk) begin
        if (s_fire && op == hsd_pkg::OP_LOAD_A && count_a_reg < CNT_W'(MAX_POINTS)) begin
            mem_a[count_a_reg[IDX_W-1:0]] <= {s_z_coord, s_y_coord, s_x_coord};
        end
        if (s_fire && op == hsd_pkg::OP_LOAD_B && count_b_reg < CNT_W'(MAX_POINTS)) begin
            mem_b[count_b_reg[IDX_W-1:0]] <= {s_z_coord, s_y_coord, s_x_coord};
        end
        rd_a_reg <= mem_a[addr_a];
        rd_b_reg <= mem_b[addr_b];
    end

    // Control registers: state, counts, drop flag, walk counters, read tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hsd_pkg::ST_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
            drop_reg    <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            dir_reg     <= 1'b0;
            tag1_reg    <= '0;
        end else begin
            state_reg <= state_next;
            tag1_reg  <= issue_tag;
            if (s_fire) begin
                unique case (op)
                    hsd_pkg::OP_LOAD_A: begin
                        if (count_a_reg < CNT_W'(MAX_POINTS)) count_a_reg <= count_a_reg + 1'b1;
                        else drop_reg <= 1'b1;
                    end
                    hsd_pkg::OP_LOAD_B: begin
                        if (count_b_reg < CNT_W'(MAX_POINTS)) count_b_reg <= count_b_reg + 1'b1;
                        else drop_reg <= 1'b1;
                    end
                    hsd_pkg::OP_CLEAR: begin
                        count_a_reg <= '0;
                        count_b_reg <= '0;
                        drop_reg    <= 1'b0;
                    end
                    hsd_pkg::OP_COMPUTE: begin
                        i_reg   <= '0;
                        j_reg   <= '0;
                        dir_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end else if (walk_en) begin
                if (last_j) begin
                    j_reg <= '0;
                    if (last_i) begin
                        i_reg   <= '0;
                        dir_reg <= 1'b1;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
        end
    end

    hsd_dist_pipe #(
        .COORD_BITS (COORD_BITS),
        .DSQ_W      (DSQ_W)
    ) u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag_i   (tag1_reg),
        .pa_i    (rd_a_reg),
        .pb_i    (rd_b_reg),
        .tag_o   (tag4),
        .dsq_o   (dsq4)
    );

    // Running minimum over the inner set, maximum of minima over both directions
    assign new_min = (tag4.first || dsq4 < min_reg) ? dsq4 : min_reg;

    always_ff @(posedge aclk) begin
        if (s_fire && op == hsd_pkg::OP_COMPUTE) begin
            best_reg <= '0;
        end else if (tag4.vld) begin
            min_reg <= new_min;
            if (tag4.last_j && new_min > best_reg) best_reg <= new_min;
        end
    end

    hsd_root_chain #(
        .DSQ_W  (DSQ_W),
        .ROOT_W (ROOT_W)
    ) u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .vld_i   (launch_root),
        .x_i     (best_reg),
        .vld_o   (root_vld),
        .root_o  (root)
    );

    // Result holding register
    always_ff @(posedge aclk) begin
        if (s_fire && op == hsd_pkg::OP_COMPUTE && any_empty) begin
            res_root_reg <= '0;
            res_dsq_reg  <= '0;
            res_inf_reg  <= a_empty ^ b_empty;
        end else if (state_reg == hsd_pkg::ST_WAIT && root_vld) begin
            res_root_reg <= root;
            res_dsq_reg  <= best_reg;
            res_inf_reg  <= 1'b0;
        end
    end

    assign m_distance         = hsd_pkg::DIST_W'(res_root_reg);
    assign m_distance_squared = hsd_pkg::DSQ_OUT_W'(res_dsq_reg);
    assign m_is_infinite      = res_inf_reg;
    assign m_overflow_drop    = drop_reg;

endmodule

FILE: rtl/core/hsd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for point_set_hausdorff_distance, attached by bind.
// Depends on hsd_pkg for result widths.
module hsd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [hsd_pkg::DIST_W-1:0]    m_distance,
    input logic [hsd_pkg::DSQ_OUT_W-1:0] m_distance_squared,
    input logic                          m_is_infinite
);

    // Hold a stalled result transaction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance_squared))
        else $error("result changed while stalled");

    // No new transaction taken while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while result pending");

    // Infinite result carries zero distance
    a_inf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_infinite |-> m_distance_squared == '0 && m_distance == '0)
        else $error("infinite result with nonzero distance");

    // Zero squared distance gives zero root
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_distance_squared == '0 |-> m_distance == '0)
        else $error("root nonzero for zero square");

endmodule

bind point_set_hausdorff_distance hsd_checker u_hsd_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_distance         (m_distance),
    .m_distance_squared (m_distance_squared),
    .m_is_infinite      (m_is_infinite)
);

FILE: verif/point_set_hausdorff_distance_test.sv
`timescale 1ns / 1ps
// Self-checking bench for point_set_hausdorff_distance: directed rows, random episodes
// of loads and computes, a full-set phase; checked by a built-in predictor or typed rows.
// Depends on hsd_pkg and the point_set_hausdorff_distance RTL only.
module point_set_hausdorff_distance_test;

    localparam int NPTS = hsd_pkg::MAX_POINTS_DEF;
    localparam int CW = hsd_pkg::COORD_BITS_DEF;
    localparam int DW = hsd_pkg::DIST_W;
    localparam int QW = hsd_pkg::DSQ_OUT_W;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic [DW-1:0] distance;
        logic [QW-1:0] dsq;
        logic          inf;
        logic          drop;
    } hd_result_t;

    typedef struct {
        hsd_pkg::op_t op;
        coord_t       x, y, z;
        bit           typed;
        hd_result_t   res;
    } stim_row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_op = hsd_pkg::OP_LOAD_A;
    coord_t s_x_coord = '0, s_y_coord = '0, s_z_coord = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [DW-1:0] m_distance;
    logic [QW-1:0] m_distance_squared;
    logic m_is_infinite;
    logic m_overflow_drop;

    // Predictor state: mirrored point sets, counts and drop flag
    longint pa_x[NPTS], pa_y[NPTS], pa_z[NPTS];
    longint pb_x[NPTS], pb_y[NPTS], pb_z[NPTS];
    int cnt_a, cnt_b;
    bit drop_seen;

    hd_result_t pending_results[$];
    stim_row_t dir_rows[$];
    int errors = 0;
    int n_items = 0, n_results = 0, n_inf = 0, n_drop = 0;
    int stall_left = 0;
    bit no_stall = 0;
    int idle_cycles = 0;

    point_set_hausdorff_distance uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_x_coord(s_x_coord), .s_y_coord(s_y_coord), .s_z_coord(s_z_coord),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_distance(m_distance), .m_distance_squared(m_distance_squared),
        .m_is_infinite(m_is_infinite), .m_overflow_drop(m_overflow_drop)
    );

    always #2 aclk = ~aclk;

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned pair_dsq(longint ax, longint ay, longint az,
                                                 longint bx, longint by, longint bz);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) + (az - bz) * (az - bz);
    endfunction

    // Directed max-of-min, A to B when a_to_b is set, else B to A
    function automatic longint unsigned directed_dsq(bit a_to_b);
        longint unsigned best, mn, d;
        int np, nq;
        best = 0;
        np = a_to_b ? cnt_a : cnt_b;
        nq = a_to_b ? cnt_b : cnt_a;
        for (int i = 0; i < np; i++) begin
            mn = '1;
            for (int j = 0; j < nq; j++) begin
                if (a_to_b) d = pair_dsq(pa_x[i], pa_y[i], pa_z[i], pb_x[j], pb_y[j], pb_z[j]);
                else d = pair_dsq(pb_x[i], pb_y[i], pb_z[i], pa_x[j], pa_y[j], pa_z[j]);
                if (d < mn) mn = d;
            end
            if (mn > best) best = mn;
        end
        return best;
    endfunction

    // Advance predictor state; return 1 with the result for a compute
    function automatic bit hausdorff_step(hsd_pkg::op_t op, coord_t x, coord_t y, coord_t z,
                                          output hd_result_t r);
        longint unsigned d1, d2, dsq;
        r = '{default: 0};
        case (op)
            hsd_pkg::OP_LOAD_A: begin
                if (cnt_a >= NPTS) drop_seen = 1;
                else begin
                    pa_x[cnt_a] = x; pa_y[cnt_a] = y; pa_z[cnt_a] = z;
                    cnt_a++;
                end
                return 0;
            end
            hsd_pkg::OP_LOAD_B: begin
                if (cnt_b >= NPTS) drop_seen = 1;
                else begin
                    pb_x[cnt_b] = x; pb_y[cnt_b] = y; pb_z[cnt_b] = z;
                    cnt_b++;
                end
                return 0;
            end
            hsd_pkg::OP_CLEAR: begin
                cnt_a = 0; cnt_b = 0; drop_seen = 0;
                return 0;
            end
            default: begin
                dsq = 0;
                if (cnt_a != 0 && cnt_b != 0) begin
                    d1 = directed_dsq(1);
                    d2 = directed_dsq(0);
                    dsq = (d1 > d2) ? d1 : d2;
                end else if (cnt_a != 0 || cnt_b != 0) begin
                    r.inf = 1;
                end
                r.distance = DW'(floor_root(dsq));
                r.dsq = QW'(dsq);
                r.drop = drop_seen;
                return 1;
            end
        endcase
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (no_stall || p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic coord_t rand_coord();
        if ($urandom_range(0, 1)) return coord_t'($urandom);
        return coord_t'($urandom_range(0, 200)) - coord_t'(100);
    endfunction

    // Drive one transaction and wait for acceptance; queue its expected result
    task automatic send_item(hsd_pkg::op_t op, coord_t x, coord_t y, coord_t z,
                             bit typed, hd_result_t typed_res);
        hd_result_t r, exp_res;
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_op <= op;
        s_x_coord <= x;
        s_y_coord <= y;
        s_z_coord <= z;
        do @(posedge aclk); while (!s_ready);
        n_items++;
        if (hausdorff_step(op, x, y, z, r)) begin
            exp_res = typed ? typed_res : r;
            pending_results = {pending_results, exp_res};
            if (typed && typed_res != r)
                $display("%0t: note: typed row differs from predictor", $time);
        end
    endtask

    task automatic send_rand(hsd_pkg::op_t op);
        send_item(op, rand_coord(), rand_coord(), rand_coord(), 0, '{default: 0});
    endtask

    task automatic add_row(hsd_pkg::op_t op, coord_t x, coord_t y, coord_t z, bit typed,
                           hd_result_t res);
        stim_row_t new_row;
        new_row = '{op, x, y, z, typed, res};
        dir_rows = {dir_rows, new_row};
    endtask

    // Receiver stalls: random low stretches, none while no_stall holds
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1;
            if (!no_stall && $urandom_range(0, 7) == 0) stall_left <= gap_len();
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge aclk) begin
        hd_result_t e;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result distance=%0d dsq=%0d", $time, m_distance,
                         m_distance_squared);
            end else begin
                e = pending_results.pop_front();
                if (m_is_infinite) n_inf++;
                if (m_overflow_drop) n_drop++;
                if (m_distance !== e.distance) begin
                    errors++;
                    $display("%0t: distance exp %0d got %0d", $time, e.distance, m_distance);
                end
                if (m_distance_squared !== e.dsq) begin
                    errors++;
                    $display("%0t: distance_squared exp %0d got %0d", $time, e.dsq,
                             m_distance_squared);
                end
                if (m_is_infinite !== e.inf) begin
                    errors++;
                    $display("%0t: is_infinite exp %0d got %0d", $time, e.inf, m_is_infinite);
                end
                if (m_overflow_drop !== e.drop) begin
                    errors++;
                    $display("%0t: overflow_drop exp %0d got %0d", $time, e.drop,
                             m_overflow_drop);
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        hd_result_t zero_res, inf_res;
        stim_row_t row;
        coord_t cmin, cmax;
        int na, nb;

        zero_res = '{default: 0};
        inf_res = '{default: 0};
        inf_res.inf = 1;
        cmin = {1'b1, {(CW-1){1'b0}}};
        cmax = {1'b0, {(CW-1){1'b1}}};
        cnt_a = 0; cnt_b = 0; drop_seen = 0;

        // Directed rows: empty sets, one set empty, extremes, clear
        add_row(hsd_pkg::OP_COMPUTE, cmax, cmin, cmax, 1, zero_res);
        add_row(hsd_pkg::OP_LOAD_A, 1, 2, 3, 0, zero_res);
        add_row(hsd_pkg::OP_COMPUTE, 0, 0, 0, 1, inf_res);
        add_row(hsd_pkg::OP_LOAD_B, 4, 6, 3, 0, zero_res);
        add_row(hsd_pkg::OP_COMPUTE, 0, 0, 0, 0, zero_res);
        add_row(hsd_pkg::OP_LOAD_A, cmin, cmin, cmin, 0, zero_res);
        add_row(hsd_pkg::OP_LOAD_B, cmax, cmax, cmax, 0, zero_res);
        add_row(hsd_pkg::OP_COMPUTE, cmin, cmax, cmin, 0, zero_res);
        add_row(hsd_pkg::OP_LOAD_B, -1, 0, -1, 0, zero_res);
        add_row(hsd_pkg::OP_COMPUTE, 0, 0, 0, 0, zero_res);
        add_row(hsd_pkg::OP_CLEAR, cmax, cmax, cmin, 0, zero_res);
        add_row(hsd_pkg::OP_COMPUTE, 0, 0, 0, 1, zero_res);
        add_row(hsd_pkg::OP_LOAD_B, cmax, 0, cmin, 0, zero_res);
        add_row(hsd_pkg::OP_COMPUTE, 0, 0, 0, 1, inf_res);
        add_row(hsd_pkg::OP_LOAD_A, cmax, 0, cmin, 0, zero_res);
        add_row(hsd_pkg::OP_COMPUTE, 0, 0, 0, 0, zero_res);
        add_row(hsd_pkg::OP_CLEAR, 0, 0, 0, 0, zero_res);

        // Hold reset, then release it
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_item(row.op, row.x, row.y, row.z, row.typed, row.res);
        end

        // Random episodes: small sets, interleaved loads, one or two computes
        while (n_items < 275) begin
            no_stall = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 2) != 0) send_rand(hsd_pkg::OP_CLEAR);
            na = $urandom_range(0, 9);
            nb = $urandom_range(0, 9);
            while (na > 0 || nb > 0) begin
                if (nb == 0 || (na > 0 && $urandom_range(0, 1))) begin
                    send_rand(hsd_pkg::OP_LOAD_A); na--;
                end else begin
                    send_rand(hsd_pkg::OP_LOAD_B); nb--;
                end
            end
            send_rand(hsd_pkg::OP_COMPUTE);
            if ($urandom_range(0, 3) == 0) begin
                send_rand($urandom_range(0, 1) ? hsd_pkg::OP_LOAD_A : hsd_pkg::OP_LOAD_B);
                send_rand(hsd_pkg::OP_COMPUTE);
            end
        end
        no_stall = 0;

        // Set A full with drops, three B points, two computes, then clear and compute
        send_rand(hsd_pkg::OP_CLEAR);
        repeat (NPTS + 2) send_rand(hsd_pkg::OP_LOAD_A);
        repeat (3) send_rand(hsd_pkg::OP_LOAD_B);
        send_rand(hsd_pkg::OP_COMPUTE);
        send_rand(hsd_pkg::OP_COMPUTE);
        send_rand(hsd_pkg::OP_CLEAR);
        send_item(hsd_pkg::OP_COMPUTE, 0, 0, 0, 1, zero_res);

        s_valid <= 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("Run sent %0d transactions and checked %0d distances", n_items, n_results);
        $display("(%0d with one set empty, %0d after dropped loads).", n_inf, n_drop);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
